@@ rtl/bmpw_pkg.sv @@
package bmpw_pkg;

    localparam int CFG_W      = 13;
    localparam int LEVEL_W    = 24;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    localparam logic [7:0] CHANNEL_MAX = 8'd255;

    localparam int HDR_BYTES      = 54;
    localparam int INFO_BYTES     = 40;
    localparam int PLANES         = 1;
    localparam int BITS_PER_PIXEL = 24;

    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_M = 8'h4D;

    // header is the 2-byte signature followed by 32-bit little-endian words
    localparam logic [5:0] HDR_SIG_B     = 6'd0;
    localparam logic [5:0] HDR_SIG_M     = 6'd1;
    localparam logic [5:0] HDR_WORD_BASE = 6'd2;
    localparam logic [5:0] HDR_LAST      = 6'(HDR_BYTES - 1);

    localparam logic [3:0] WORD_FILE_SIZE  = 4'd0;
    localparam logic [3:0] WORD_DATA_OFS   = 4'd2;
    localparam logic [3:0] WORD_INFO_SIZE  = 4'd3;
    localparam logic [3:0] WORD_WIDTH      = 4'd4;
    localparam logic [3:0] WORD_HEIGHT     = 4'd5;
    localparam logic [3:0] WORD_PLANES_BPP = 4'd6;
    localparam logic [3:0] WORD_IMAGE_SIZE = 4'd8;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] red_level;
        logic signed [LEVEL_W-1:0] green_level;
        logic signed [LEVEL_W-1:0] blue_level;
    } pixel_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } stream_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       header;
        logic [1:0] pad_count;
        logic       file_end;
    } slot_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_BLUE,
        PH_GREEN,
        PH_RED,
        PH_PAD
    } phase_t;

endpackage

@@ rtl/bmpw_lane.sv @@
module bmpw_lane
    import bmpw_pkg::*;
(
    input  logic signed [LEVEL_W-1:0] level,
    output logic        [7:0]         channel
);

    logic [LEVEL_W+7:0] scaled;
    logic [15:0]        whole;

    // 255 * v as (v << 8) - v, only used when v is non-negative
    assign scaled = ({8'b0, level} << 8) - {8'b0, level};
    assign whole  = scaled[LEVEL_W+7:16];

    always_comb
    begin
        if (level[LEVEL_W-1])
        begin
            channel = 8'd0;
        end
        else if (whole > 16'(CHANNEL_MAX))
        begin
            channel = CHANNEL_MAX;
        end
        else
        begin
            channel = whole[7:0];
        end
    end

endmodule

@@ rtl/bmpw_cfg.sv @@
module bmpw_cfg
    import bmpw_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int DIM_W         = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic [DIM_W-1:0]      width,
    output logic [DIM_W-1:0]      height,
    output logic [1:0]            pad,
    output logic [31:0]           pixel_bytes,
    output logic [31:0]           file_size
);

    localparam int ROW_W  = DIM_W + 2;
    localparam int PROD_W = DIM_W + ROW_W;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [ROW_W-1:0]  row_bytes_reg;
    logic [ROW_W-1:0]  row_bytes_next;
    logic [31:0]       pixel_bytes_reg;
    logic [31:0]       pixel_bytes_next;
    logic [31:0]       file_size_reg;
    logic [31:0]       file_size_next;
    logic [PROD_W-1:0] product;
    logic [31:0]       width_word;
    logic              wr_en;
    reg_index_t        index;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > 32'(MAX_DIMENSION))
        begin
            r = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    assign index = reg_index_t'(paddr[2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = 32'd0;
        endcase
    end

    assign width      = clamp_dim(width_reg);
    assign height     = clamp_dim(height_reg);
    assign width_word = 32'(width);
    assign pad        = width_word[1:0];

    // pixel array size h * (3w + pad) over two register stages, then + header size in file_size_reg
    assign row_bytes_next   = (ROW_W'(width) << 1) + ROW_W'(width) + ROW_W'(pad);
    assign product          = PROD_W'(height) * PROD_W'(row_bytes_reg);
    assign pixel_bytes_next = 32'(product);
    assign file_size_next   = pixel_bytes_reg + 32'(HDR_BYTES);

    always_ff @(posedge clk)
    begin
        row_bytes_reg   <= row_bytes_next;
        pixel_bytes_reg <= pixel_bytes_next;
        file_size_reg   <= file_size_next;
    end

    assign pixel_bytes = pixel_bytes_reg;
    assign file_size   = file_size_reg;

endmodule

@@ rtl/bmpw_emit.sv @@
module bmpw_emit
    import bmpw_pkg::*;
#(
    parameter int DIM_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  slot_t            slot,
    output logic             ready,
    input  logic [DIM_W-1:0] width,
    input  logic [DIM_W-1:0] height,
    input  logic [31:0]      pixel_bytes,
    input  logic [31:0]      file_size,
    output logic             stream_valid,
    input  logic             stream_stall,
    output stream_t          stream
);

    slot_t      slot_reg;
    logic       slot_valid_reg;
    logic       slot_valid_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     phase_step;
    logic [5:0] hdr_idx_reg;
    logic [5:0] hdr_idx_next;
    logic [5:0] hdr_idx_step;
    logic [1:0] pad_idx_reg;
    logic [1:0] pad_idx_next;
    logic [1:0] pad_idx_step;
    logic       out_valid_reg;
    logic       out_valid_next;
    stream_t    out_reg;
    stream_t    cur;
    logic       out_free;
    logic       fire;
    logic       slot_done;

    function automatic logic [7:0] header_byte(
        input logic [5:0]  idx,
        input logic [31:0] w,
        input logic [31:0] h,
        input logic [31:0] pix,
        input logic [31:0] size
    );
        logic [5:0]  rel;
        logic [31:0] word;
        logic [7:0]  b;
        rel = idx - HDR_WORD_BASE;
        unique case (rel[5:2])
            WORD_FILE_SIZE:  word = size;
            WORD_DATA_OFS:   word = 32'(HDR_BYTES);
            WORD_INFO_SIZE:  word = 32'(INFO_BYTES);
            WORD_WIDTH:      word = w;
            WORD_HEIGHT:     word = h;
            WORD_PLANES_BPP: word = {16'(BITS_PER_PIXEL), 16'(PLANES)};
            WORD_IMAGE_SIZE: word = pix;
            default:         word = 32'd0;
        endcase
        priority if (idx == HDR_SIG_B)
        begin
            b = CHAR_B;
        end
        else if (idx == HDR_SIG_M)
        begin
            b = CHAR_M;
        end
        else
        begin
            b = word[8*rel[1:0] +: 8];
        end
        return b;
    endfunction

    assign out_free = !out_valid_reg || !stream_stall;
    assign fire     = slot_valid_reg && out_free;

    always_comb
    begin
        cur.file_byte   = 8'd0;
        cur.end_of_file = 1'b0;
        slot_done       = 1'b0;
        phase_step      = phase_reg;
        hdr_idx_step    = hdr_idx_reg;
        pad_idx_step    = pad_idx_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                cur.file_byte = header_byte(hdr_idx_reg, 32'(width), 32'(height),
                                            pixel_bytes, file_size);
                if (fire)
                begin
                    hdr_idx_step = hdr_idx_reg + 6'd1;
                    if (hdr_idx_reg == HDR_LAST)
                    begin
                        phase_step = PH_BLUE;
                    end
                end
            end
            PH_BLUE:
            begin
                cur.file_byte = slot_reg.blue;
                if (fire)
                begin
                    phase_step = PH_GREEN;
                end
            end
            PH_GREEN:
            begin
                cur.file_byte = slot_reg.green;
                if (fire)
                begin
                    phase_step = PH_RED;
                end
            end
            PH_RED:
            begin
                cur.file_byte   = slot_reg.red;
                slot_done       = (slot_reg.pad_count == 2'd0);
                cur.end_of_file = slot_reg.file_end && slot_done;
                if (fire)
                begin
                    phase_step   = PH_PAD;
                    pad_idx_step = 2'd0;
                end
            end
            PH_PAD:
            begin
                slot_done       = (pad_idx_reg == slot_reg.pad_count - 2'd1);
                cur.end_of_file = slot_reg.file_end && slot_done;
                if (fire)
                begin
                    pad_idx_step = pad_idx_reg + 2'd1;
                end
            end
            default:
            begin
                phase_step = PH_BLUE;
            end
        endcase
    end

    // a new pixel can enter while the last byte of this one goes out
    assign ready = !slot_valid_reg || (fire && slot_done);

    always_comb
    begin
        phase_next   = phase_step;
        hdr_idx_next = hdr_idx_step;
        pad_idx_next = pad_idx_step;

        if (load)
        begin
            phase_next   = slot.header ? PH_HEADER : PH_BLUE;
            hdr_idx_next = 6'd0;
            pad_idx_next = 2'd0;
        end

        if (load)
        begin
            slot_valid_next = 1'b1;
        end
        else if (fire && slot_done)
        begin
            slot_valid_next = 1'b0;
        end
        else
        begin
            slot_valid_next = slot_valid_reg;
        end

        out_valid_next = out_free ? fire : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_BLUE;
            hdr_idx_reg    <= 6'd0;
            pad_idx_reg    <= 2'd0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            pad_idx_reg    <= pad_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= slot;
        end
        if (fire)
        begin
            out_reg <= cur;
        end
    end

    assign stream_valid = out_valid_reg;
    assign stream       = out_reg;

endmodule

@@ rtl/bmp_rgb24_stream_writer.sv @@
// channel   dir   handshake                      payload
// pixel     in    pixel_valid / pixel_stall      pixel_t: red, green, blue levels
// stream    out   stream_valid / stream_stall    stream_t: file_byte, end_of_file
// apb       in    psel / penable / pready        image_width at 0x0, image_height at 0x4
//
// one output byte per cycle while the stream does not stall: a pixel gives 3 bytes,
// plus width mod 4 at a row end and 54 more for the header on the first pixel of a
// file; the byte output sets the pixel rate; a pixel enters the hold stage while
// the previous one sends its last byte; a pixel is registered in the hold stage and
// its first byte then in the output register; reset clears the row, column and
// header state and sets both dimensions to 1; a stall on the stream holds the output
// register and the pixel side stalls once the hold stage is full
module bmp_rgb24_stream_writer
    import bmpw_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_t                pixel,
    output logic                  stream_valid,
    input  logic                  stream_stall,
    output stream_t               stream
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [1:0]       pad;
    logic [31:0]      pixel_bytes;
    logic [31:0]      file_size;

    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    logic             header_sent_reg;
    logic             header_sent_next;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;
    logic             row_end;
    logic             file_end;
    logic             accept;
    logic             emit_ready;
    slot_t            slot;

    assign pready = 1'b1;

    bmpw_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .DIM_W        (DIM_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .width      (width),
        .height     (height),
        .pad        (pad),
        .pixel_bytes(pixel_bytes),
        .file_size  (file_size)
    );

    bmpw_lane u_lane_blue (
        .level  (pixel.blue_level),
        .channel(slot.blue)
    );

    bmpw_lane u_lane_green (
        .level  (pixel.green_level),
        .channel(slot.green)
    );

    bmpw_lane u_lane_red (
        .level  (pixel.red_level),
        .channel(slot.red)
    );

    assign accept      = pixel_valid && emit_ready;
    assign pixel_stall = !emit_ready;

    // row and file end follow the dimensions as they stand at this pixel
    assign col_inc  = {1'b0, col_reg} + {{DIM_W{1'b0}}, 1'b1};
    assign row_inc  = {1'b0, row_reg} + {{DIM_W{1'b0}}, 1'b1};
    assign row_end  = (col_inc >= {1'b0, width});
    assign file_end = row_end && (row_inc >= {1'b0, height});

    assign slot.header    = !header_sent_reg;
    assign slot.pad_count = row_end ? pad : 2'd0;
    assign slot.file_end  = file_end;

    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        header_sent_next = header_sent_reg;
        if (accept)
        begin
            priority if (file_end)
            begin
                col_next         = '0;
                row_next         = '0;
                header_sent_next = 1'b0;
            end
            else if (row_end)
            begin
                col_next         = '0;
                row_next         = row_inc[DIM_W-1:0];
                header_sent_next = 1'b1;
            end
            else
            begin
                col_next         = col_inc[DIM_W-1:0];
                header_sent_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            header_sent_reg <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            header_sent_reg <= header_sent_next;
        end
    end

    bmpw_emit #(
        .DIM_W(DIM_W)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .slot        (slot),
        .ready       (emit_ready),
        .width       (width),
        .height      (height),
        .pixel_bytes (pixel_bytes),
        .file_size   (file_size),
        .stream_valid(stream_valid),
        .stream_stall(stream_stall),
        .stream      (stream)
    );

endmodule

@@ tb/bmp_rgb24_stream_writer_tb.sv @@
`timescale 1ns / 1ps

module bmp_rgb24_stream_writer_tb;
    import bmpw_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_PIXELS = 350;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  pixel_valid;
    logic                  pixel_stall;
    pixel_t                pixel;
    logic                  stream_valid;
    logic                  stream_stall;
    stream_t               stream;

    // predictor state: register copies and file progress
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic             header_done;
    int unsigned      col_count;
    int unsigned      row_count;

    stream_t expected_bytes[$];

    int  errors;
    int  pixels_sent;
    int  bytes_checked;
    int  files_closed;
    int  phases;
    int  cycle_count;
    int  hold_cycles;
    bit  tx_calm;
    bit  rx_calm;

    bmp_rgb24_stream_writer #(
        .MAX_DIMENSION(MAX_DIM)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .stream       (stream)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned clamp_dimension(logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (32'(v) > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic logic [7:0] level_to_byte(logic signed [LEVEL_W-1:0] lv);
        logic [63:0] scaled;
        if (lv[LEVEL_W-1])
            return 8'd0;
        scaled = ({40'd0, lv} * 64'd255) >> 16;
        return (scaled > 64'd255) ? CHANNEL_MAX : scaled[7:0];
    endfunction

    function automatic void push_byte(logic [7:0] b, logic eof);
        stream_t s;
        s.file_byte   = b;
        s.end_of_file = eof;
        expected_bytes.push_back(s);
    endfunction

    function automatic void push_word(logic [31:0] w);
        push_byte(w[7:0], 1'b0);
        push_byte(w[15:8], 1'b0);
        push_byte(w[23:16], 1'b0);
        push_byte(w[31:24], 1'b0);
    endfunction

    // bytes of the file that one accepted pixel produces
    function automatic void append_file_bytes(pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned pad;
        int unsigned data_bytes;
        logic        row_end;
        logic        file_end;
        w   = clamp_dimension(cfg_width);
        h   = clamp_dimension(cfg_height);
        pad = w % 4;
        if (!header_done)
        begin
            data_bytes = h * (3 * w + pad);
            push_byte(CHAR_B, 1'b0);
            push_byte(CHAR_M, 1'b0);
            push_word(data_bytes + HDR_BYTES);
            push_word(32'd0);
            push_word(32'(HDR_BYTES));
            push_word(32'(INFO_BYTES));
            push_word(w);
            push_word(h);
            push_byte(8'(PLANES), 1'b0);
            push_byte(8'd0, 1'b0);
            push_byte(8'(BITS_PER_PIXEL), 1'b0);
            push_byte(8'd0, 1'b0);
            push_word(32'd0);
            push_word(data_bytes);
            for (int i = 0; i < 16; i++)
                push_byte(8'd0, 1'b0);
            header_done = 1'b1;
        end
        row_end  = (col_count + 1 >= w);
        file_end = row_end && (row_count + 1 >= h);
        push_byte(level_to_byte(px.blue_level), 1'b0);
        push_byte(level_to_byte(px.green_level), 1'b0);
        push_byte(level_to_byte(px.red_level), file_end && pad == 0);
        if (row_end)
        begin
            for (int unsigned i = 0; i < pad; i++)
                push_byte(8'd0, file_end && i + 1 == pad);
            col_count = 0;
            row_count++;
        end
        else
            col_count++;
        if (file_end)
        begin
            header_done = 1'b0;
            col_count   = 0;
            row_count   = 0;
        end
    endfunction

    // pixels still needed to close the file at the current dimensions
    function automatic int unsigned pixels_to_file_end();
        int unsigned w;
        int unsigned h;
        int unsigned first_row;
        int unsigned rows_left;
        w         = clamp_dimension(cfg_width);
        h         = clamp_dimension(cfg_height);
        first_row = (col_count + 1 >= w) ? 1 : w - col_count;
        rows_left = (row_count + 1 >= h) ? 0 : h - row_count - 1;
        return first_row + rows_left * w;
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 5))
            0: return LEVEL_W'($urandom);
            1: return LEVEL_W'($urandom_range(0, 65536));
            2: return LEVEL_W'($urandom_range(65526, 65546));
            3: return {1'b1, 23'($urandom)};
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'hFFFFFF;
                    default: return 24'h000000;
                endcase
            end
            default: return LEVEL_W'($urandom_range(0, 70000));
        endcase
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        // upper bits are don't-care for the 13-bit registers
        pwdata  = {19'($urandom), value[CFG_W-1:0]};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = value[CFG_W-1:0];
        else
            cfg_height = value[CFG_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_pixel(input logic [LEVEL_W-1:0] red, green, blue);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            pixel_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel.red_level   = red;
        pixel.green_level = green;
        pixel.blue_level  = blue;
        pixel_valid       = 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        append_file_bytes(pixel);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pixel_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_reset_dimensions();
        // 1x1 default: header, one pixel, one pad byte carrying end of file
        send_pixel(24'h010000, 24'h008080, 24'h400000);
        wait_idle();
    endtask

    task automatic test_channel_extremes();
        write_reg(REG_IMAGE_WIDTH, 32'd4);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
        send_pixel(24'h7FFFFF, 24'h800000, 24'hFFFFFF);
        send_pixel(24'd0, 24'd1, 24'd256);
        send_pixel(24'd257, 24'd258, 24'd32768);
        send_pixel(24'd65535, 24'd65536, 24'd65537);
        wait_idle();
    endtask

    task automatic test_row_padding();
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd2);
        repeat (6) send_pixel(random_level(), random_level(), random_level());
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
        repeat (2) send_pixel(random_level(), random_level(), random_level());
        wait_idle();
    endtask

    task automatic test_dimension_clamp();
        // zero clamps to one
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        write_reg(REG_IMAGE_HEIGHT, 32'd0);
        send_pixel(random_level(), random_level(), random_level());
        wait_idle();
        // oversize header, then shrink mid-file so the open file closes at once
        write_reg(REG_IMAGE_WIDTH, 32'd4096);
        write_reg(REG_IMAGE_HEIGHT, 32'd8191);
        repeat (2) send_pixel(random_level(), random_level(), random_level());
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        write_reg(REG_IMAGE_HEIGHT, 32'd0);
        send_pixel(random_level(), random_level(), random_level());
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd3);
        tx_calm     = 1'b1;
        hold_cycles = 400;
        repeat (24) send_pixel(random_level(), random_level(), random_level());
        tx_calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_files();
        int          sent;
        int unsigned total;
        int unsigned n;
        logic [31:0] w;
        logic [31:0] h;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(4096, 8191));
                    h = $urandom_range(1, 4);
                end
                1:
                begin
                    w = $urandom_range(1, 9);
                    h = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(4096, 8191));
                end
                default:
                begin
                    w = $urandom_range(1, 9);
                    h = $urandom_range(1, 4);
                end
            endcase
            write_reg(REG_IMAGE_WIDTH, w);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_HEIGHT, h);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            total   = pixels_to_file_end();
            // mostly whole files; the rest leave a file open across a resize
            if (total <= 40 && $urandom_range(0, 4) != 0)
                n = total;
            else
                n = $urandom_range(1, 12);
            repeat (n) send_pixel(random_level(), random_level(), random_level());
            sent += n;
            phases++;
            wait_idle();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // result side: random stall before each transaction, plus the long hold
    initial
    begin
        int gap;
        stream_stall = 1'b0;
        forever
        begin
            if (hold_cycles > 0)
            begin
                stream_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                stream_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            stream_stall = 1'b0;
            @(posedge clk);
            while (!stream_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        stream_t want;
        if (rst_n && stream_valid && !stream_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %02h eof %b",
                         $time, stream.file_byte, stream.end_of_file);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (stream.file_byte !== want.file_byte)
                begin
                    $display("%0t: file_byte mismatch: expected %02h, actual %02h",
                             $time, want.file_byte, stream.file_byte);
                    errors++;
                end
                if (stream.end_of_file !== want.end_of_file)
                begin
                    $display("%0t: end_of_file mismatch: expected %b, actual %b",
                             $time, want.end_of_file, stream.end_of_file);
                    errors++;
                end
                bytes_checked++;
                if (want.end_of_file)
                    files_closed++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout, %0d bytes still expected", $time,
                         expected_bytes.size());
                $display("bmp_rgb24_stream_writer_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pixel_valid   = 1'b0;
        pixel         = '0;
        cfg_width     = CFG_W'(1);
        cfg_height    = CFG_W'(1);
        header_done   = 1'b0;
        col_count     = 0;
        row_count     = 0;
        errors        = 0;
        pixels_sent   = 0;
        bytes_checked = 0;
        files_closed  = 0;
        phases        = 0;
        hold_cycles   = 0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_dimensions();
        test_channel_extremes();
        test_row_padding();
        test_dimension_clamp();
        test_output_backpressure();
        test_random_files();

        repeat (20) @(negedge clk);
        $display("covered %0d pixels (%0d random dimension phases, clamped and resized files)",
                 pixels_sent, phases);
        $display("compared %0d stream bytes across %0d completed files",
                 bytes_checked, files_closed);
        if (errors == 0)
            $display("bmp_rgb24_stream_writer_tb: clean");
        else
            $display("bmp_rgb24_stream_writer_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bmpw_pkg.sv
rtl/bmpw_lane.sv
rtl/bmpw_cfg.sv
rtl/bmpw_emit.sv
rtl/bmp_rgb24_stream_writer.sv
tb/bmp_rgb24_stream_writer_tb.sv
